FILE: rtl/gntm_pkg.sv
// Package for the greedy nearest track matcher: widths, zone bounds and reset values.
// Depends on nothing; the core, the distance unit and the bench import it.
`timescale 1ns / 1ps
`default_nettype none
package gntm_pkg;
  localparam int COORD_W      = 14;
  localparam int IDENT_W      = 16;
  localparam int RADIUS_W     = 10;
  localparam int BIAS_W       = 6;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 10;
  localparam int DIST_W       = 29;
  localparam int DEF_MAX_TRACKS = 32;
  localparam int DEF_MAX_POINTS = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_BIAS    = 1'b1;

  localparam logic [COORD_W-1:0] X_LOW_Q  = 14'd5120;
  localparam logic [COORD_W-1:0] X_HIGH_Q = 14'd10240;
  localparam logic [COORD_W-1:0] Y_LOW_Q  = 14'd2880;
  localparam logic [COORD_W-1:0] Y_HIGH_Q = 14'd5760;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 10'd100;
  localparam logic [BIAS_W-1:0]   BIAS_RESET   = 6'd20;

  // Moves an outer-zone coordinate toward the centre by bias pixels.
  function automatic logic [COORD_W-1:0] zone_shift(input logic [COORD_W-1:0] v,
                                                    input logic [COORD_W-1:0] lo,
                                                    input logic [COORD_W-1:0] hi,
                                                    input logic [BIAS_W-1:0] bias);
    logic [COORD_W-1:0] b;
    b = {{(COORD_W-BIAS_W-4){1'b0}}, bias, 4'b0000};
    if (v < lo) zone_shift = v + b;
    else if (v < hi) zone_shift = v;
    else zone_shift = v - b;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/greedy_nearest_track_matcher_core.sv
// Top level of the greedy nearest track matcher: sequencer, track and point stores.
// Depends on gntm_pkg, gntm_ram and gntm_dist.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | kind, point_x, point_y
//  out_    | output    | out_valid/stall  | person_valid, person_id, pos_x, pos_y, is_new, last
//  cfg_    | input     | cfg_wr_en        | cfg_index, cfg_data
//
// A detection request is written to the point store while the block stays idle. An
// end-of-frame request scans every stored point for each track, keeps only matched
// tracks, then appends unused points as new tracks; this is serialised by the one
// shared distance unit and the single read port of each store. Each result is then
// read in S_DRD and held in S_DOUT while out_stall is high.
// Reset (rst_n low, synchronous) empties both stores and the identifier counter.
// in_stall is high while a frame is being matched or dumped; the dump holds
// each result while out_stall is high.
`timescale 1ns / 1ps
`default_nettype none
module greedy_nearest_track_matcher_core #(
  parameter int MAX_TRACKS = gntm_pkg::DEF_MAX_TRACKS,
  parameter int MAX_POINTS = gntm_pkg::DEF_MAX_POINTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [gntm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gntm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_kind,
  input  wire logic [gntm_pkg::COORD_W-1:0]      in_point_x,
  input  wire logic [gntm_pkg::COORD_W-1:0]      in_point_y,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_person_valid,
  output logic      [gntm_pkg::IDENT_W-1:0]      out_person_id,
  output logic      [gntm_pkg::COORD_W-1:0]      out_pos_x,
  output logic      [gntm_pkg::COORD_W-1:0]      out_pos_y,
  output logic                                   out_is_new,
  output logic                                   out_last
);
  import gntm_pkg::*;

  localparam int TA_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int PA_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int TC_W = $clog2(MAX_TRACKS + 1);
  localparam int PC_W = $clog2(MAX_POINTS + 1);
  localparam int TW   = 2 * COORD_W + IDENT_W;
  localparam int PW   = 2 * COORD_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TRD   = 4'd1; // read track t
  localparam logic [3:0] S_TLAT  = 4'd2; // track data arrives
  localparam logic [3:0] S_SCAN  = 4'd3; // stream points through the distance unit
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_KEEP  = 4'd5; // read best point
  localparam logic [3:0] S_KWR   = 4'd6; // write kept track
  localparam logic [3:0] S_NRD   = 4'd7; // read leftover point
  localparam logic [3:0] S_NWR   = 4'd8;
  localparam logic [3:0] S_DRD   = 4'd9; // read for dump
  localparam logic [3:0] S_DOUT  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [RADIUS_W-1:0] radius_r;
  logic [BIAS_W-1:0]   bias_r;
  logic [TC_W-1:0] tcount_r, t_r, kept_r;
  logic [PC_W-1:0] pcount_r, c_r, ccmp_r, c_d2_r;
  logic [IDENT_W-1:0] next_id_r;
  logic [MAX_POINTS-1:0] used_r;
  logic found_r;
  logic [PA_W-1:0] best_r;
  logic [DIST_W-1:0] bestd_r, limit_r;
  logic scan_v1_r, scan_v2_r;

  // Track store.
  logic t_we;
  logic [TA_W-1:0] t_wa, t_ra;
  logic [TW-1:0] t_wd, t_rd;
  // Point store.
  logic p_we;
  logic [PA_W-1:0] p_wa, p_ra;
  logic [PW-1:0] p_wd, p_rd;

  gntm_ram #(.WIDTH(TW), .DEPTH(MAX_TRACKS)) u_tracks (
    .clk(clk), .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd),
    .rd_addr(t_ra), .rd_data(t_rd));
  gntm_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_points (
    .clk(clk), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
    .rd_addr(p_ra), .rd_data(p_rd));

  logic [COORD_W-1:0] trk_x_r, trk_y_r;
  logic [IDENT_W-1:0] trk_id_r;
  logic [DIST_W-1:0] dsq;

  gntm_dist u_dist (
    .clk(clk), .ax(trk_x_r), .ay(trk_y_r),
    .bx(p_rd[PW-1:COORD_W]), .by(p_rd[COORD_W-1:0]), .dsq(dsq));

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // limit_r is the registered square of rq; the user must only change config when idle (unchecked).
  logic [COORD_W-1:0] rq;
  assign rq = {radius_r, 4'b0000};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_kind) state_nxt = (tcount_r != '0) ? S_TRD : S_NRD;
      S_TRD:   state_nxt = S_TLAT;
      S_TLAT:  state_nxt = S_SCAN;
      S_SCAN:  if (c_r >= pcount_r) state_nxt = S_DRAIN;
      S_DRAIN: if (!scan_v1_r && !scan_v2_r) state_nxt = found_r ? S_KEEP : S_TRD;
      S_KEEP:  state_nxt = S_KWR;
      S_KWR:   state_nxt = S_TRD;
      S_NRD:   state_nxt = S_NWR;
      S_NWR:   state_nxt = S_NRD;
      S_DRD:   state_nxt = S_DOUT;
      S_DOUT:  if (out_acc) state_nxt = out_last ? S_IDLE : S_DRD;
      default: state_nxt = S_IDLE;
    endcase
    // Loop exits evaluated ahead of the generic arcs.
    if (state_r == S_TRD && t_r >= tcount_r) state_nxt = S_NRD;
    if (state_r == S_DRAIN && !scan_v1_r && !scan_v2_r && !found_r) state_nxt = S_TRD;
    if (state_r == S_NRD && c_r >= pcount_r) state_nxt = S_DRD;
  end

  always_comb begin
    t_we = 1'b0;
    t_wa = kept_r[TA_W-1:0];
    t_wd = {p_rd, trk_id_r};
    t_ra = t_r[TA_W-1:0];
    p_we = 1'b0;
    p_wa = pcount_r[PA_W-1:0];
    p_wd = {zone_shift(in_point_x, X_LOW_Q, X_HIGH_Q, bias_r),
            zone_shift(in_point_y, Y_LOW_Q, Y_HIGH_Q, bias_r)};
    p_ra = c_r[PA_W-1:0];
    case (state_r)
      S_IDLE: p_we = in_acc && !in_kind && (pcount_r < PC_W'(MAX_POINTS));
      S_KEEP: p_ra = best_r;
      S_KWR:  t_we = 1'b1;
      S_NWR: begin
        t_we = !used_r[c_d2_r[PA_W-1:0]] && (kept_r < TC_W'(MAX_TRACKS));
        t_wd = {p_rd, next_id_r};
      end
      S_DRD:  t_ra = t_r[TA_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      radius_r  <= RADIUS_RESET;
      bias_r    <= BIAS_RESET;
      tcount_r  <= '0;
      pcount_r  <= '0;
      next_id_r <= '0;
      used_r    <= '0;
      t_r <= '0; kept_r <= '0; c_r <= '0; ccmp_r <= '0; c_d2_r <= '0;
      found_r <= 1'b0; scan_v1_r <= 1'b0; scan_v2_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_MATCH_RADIUS: radius_r <= cfg_data[RADIUS_W-1:0];
          REG_ZONE_BIAS:    bias_r   <= cfg_data[BIAS_W-1:0];
          default: ;
        endcase
      end
      // A point read is issued in the scan state; its flag follows the data.
      scan_v1_r <= (state_r == S_SCAN) && (c_r < pcount_r) && !used_r[c_r[PA_W-1:0]];
      scan_v2_r <= scan_v1_r;
      case (state_r)
        S_IDLE: begin
          t_r <= '0; kept_r <= '0; c_r <= '0;
          if (p_we) pcount_r <= pcount_r + 1'b1;
        end
        S_TRD: begin
          c_r <= '0;
          found_r <= 1'b0;
        end
        S_TLAT: begin
          trk_x_r  <= t_rd[TW-1 -: COORD_W];
          trk_y_r  <= t_rd[IDENT_W +: COORD_W];
          trk_id_r <= t_rd[IDENT_W-1:0];
        end
        S_SCAN: begin
          // Issue read for point c; data valid next cycle, distance the one after.
          if (c_r < pcount_r) c_r <= c_r + 1'b1;
          ccmp_r <= c_r;
          c_d2_r <= ccmp_r;
        end
        default: ;
      endcase
      if (state_r == S_DRAIN) begin
        ccmp_r <= c_r;
        c_d2_r <= ccmp_r;
      end
      // Compare stage, shared by scan and drain.
      if (scan_v2_r && dsq < limit_r && (!found_r || dsq < bestd_r)) begin
        found_r <= 1'b1;
        best_r  <= c_d2_r[PA_W-1:0];
        bestd_r <= dsq;
      end
      if (state_r == S_DRAIN && !scan_v1_r && !scan_v2_r && !found_r) t_r <= t_r + 1'b1;
      if (state_r == S_KWR) begin
        used_r[best_r] <= 1'b1;
        kept_r <= kept_r + 1'b1;
        t_r <= t_r + 1'b1;
      end
      if (state_r == S_NRD) begin
        c_d2_r <= c_r;
        c_r <= c_r + 1'b1;
        if (c_r >= pcount_r) begin
          // kept_r now holds the final count of the table.
          t_r <= '0;
          tcount_r <= kept_r;
          pcount_r <= '0;
        end
      end
      if (state_r == S_NWR && t_we) begin
        next_id_r <= next_id_r + 1'b1;
        kept_r <= kept_r + 1'b1;
      end
      if (state_r == S_DOUT && out_acc) begin
        out_valid <= 1'b0;
        t_r <= t_r + 1'b1;
        if (out_last) used_r <= '0;
      end
      if (state_r == S_DRD) out_valid <= 1'b1;
    end
  end

  // Squared limit, recomputed every cycle from the radius register.
  always_ff @(posedge clk) begin
    limit_r <= DIST_W'(rq) * DIST_W'(rq);
  end

  // Count of tracks matched this frame, for the is_new flag.
  logic [TC_W-1:0] matched_r;
  always_ff @(posedge clk) begin
    if (!rst_n) matched_r <= '0;
    else if (state_r == S_NRD && c_r == '0) matched_r <= kept_r;
  end

  assign out_person_valid = (tcount_r != '0);
  assign out_person_id    = out_person_valid ? t_rd[IDENT_W-1:0] : '0;
  assign out_pos_x        = out_person_valid ? t_rd[TW-1 -: COORD_W] : '0;
  assign out_pos_y        = out_person_valid ? t_rd[IDENT_W +: COORD_W] : '0;
  assign out_is_new       = out_person_valid && (t_r >= matched_r);
  assign out_last         = !out_person_valid || (t_r + 1'b1 == tcount_r);
endmodule
`default_nettype wire

FILE: rtl/gntm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module gntm_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: rtl/gntm_dist.sv
// Shared distance unit: registered squared Euclidean distance of two Q10.4 points.
// Depends on gntm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gntm_dist (
  input  wire logic                   clk,
  input  wire logic [gntm_pkg::COORD_W-1:0] ax,
  input  wire logic [gntm_pkg::COORD_W-1:0] ay,
  input  wire logic [gntm_pkg::COORD_W-1:0] bx,
  input  wire logic [gntm_pkg::COORD_W-1:0] by,
  output logic      [gntm_pkg::DIST_W-1:0]  dsq
);
  import gntm_pkg::*;
  logic [COORD_W-1:0] dx, dy;
  logic [2*COORD_W-1:0] sqx_r, sqy_r;
  assign dx = (ax > bx) ? ax - bx : bx - ax;
  assign dy = (ay > by) ? ay - by : by - ay;
  // Two squares registered, then one add.
  always_ff @(posedge clk) begin
    sqx_r <= dx * dx;
    sqy_r <= dy * dy;
  end
  assign dsq = {1'b0, sqx_r} + {1'b0, sqy_r};
endmodule
`default_nettype wire

FILE: bench/tb_greedy_nearest_track_matcher_core.sv
// Self-checking bench for greedy_nearest_track_matcher_core: random and directed detection
// frames, a track-table predictor in the bench, and a per-field check of every table dump.
// Depends on gntm_pkg and the matcher RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_greedy_nearest_track_matcher_core;
  import gntm_pkg::*;

  localparam int NTRK = 32;
  localparam int NPT  = 32;

  typedef struct packed {
    logic             kind;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } det_req_t;

  typedef struct packed {
    logic               pv;
    logic [IDENT_W-1:0] id;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               is_new;
    logic               last;
  } person_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_kind = 1'b0;
  logic [COORD_W-1:0] in_point_x = '0;
  logic [COORD_W-1:0] in_point_y = '0;
  logic out_stall = 1'b0;
  wire in_stall, out_valid, out_person_valid, out_is_new, out_last;
  wire [IDENT_W-1:0] out_person_id;
  wire [COORD_W-1:0] out_pos_x, out_pos_y;

  greedy_nearest_track_matcher_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_person_valid(out_person_valid), .out_person_id(out_person_id),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_is_new(out_is_new), .out_last(out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: the bench's own copy of the track table and point buffer.
  logic [RADIUS_W-1:0] radius_q;
  logic [BIAS_W-1:0]   bias_q;
  logic [COORD_W-1:0]  trk_x [NTRK];
  logic [COORD_W-1:0]  trk_y [NTRK];
  logic [IDENT_W-1:0]  trk_id [NTRK];
  int                  trk_n;
  logic [COORD_W-1:0]  pt_x [NPT];
  logic [COORD_W-1:0]  pt_y [NPT];
  bit                  pt_used [NPT];
  int                  pt_n;
  logic [IDENT_W-1:0]  ident_next;

  det_req_t pending_reqs[$];
  person_t  expected_persons[$];
  int       errors = 0;
  bit       drv_hold = 1'b0;   // driver pause requested by the stimulus process
  int       rx_hold = 0;       // cycles of forced receiver hold-off still to run

  // Outer thirds are pulled toward the centre; the wrap is kept at 14 bits.
  function automatic logic [COORD_W-1:0] centre_pull(logic [COORD_W-1:0] v,
      logic [COORD_W-1:0] lo, logic [COORD_W-1:0] hi, logic [BIAS_W-1:0] b);
    logic [COORD_W-1:0] off;
    off = COORD_W'(b) << 4;
    if (v < lo) return v + off;
    if (v < hi) return v;
    return v - off;
  endfunction

  // Works out the effect of one accepted request and queues any table dump.
  task automatic predict_frame(det_req_t r);
    longint lim, dx, dy, d, bestd;
    int kept, best;
    bit found;
    person_t p;
    if (!r.kind) begin
      if (pt_n < NPT) begin
        pt_x[pt_n] = centre_pull(r.px, X_LOW_Q, X_HIGH_Q, bias_q);
        pt_y[pt_n] = centre_pull(r.py, Y_LOW_Q, Y_HIGH_Q, bias_q);
        pt_used[pt_n] = 1'b0;
        pt_n++;
      end
      return;
    end
    lim = longint'(radius_q) * 16;
    lim = lim * lim;
    kept = 0;
    for (int t = 0; t < trk_n; t++) begin
      found = 1'b0; best = 0; bestd = 0;
      for (int c = 0; c < pt_n; c++) begin
        if (pt_used[c]) continue;
        dx = longint'(trk_x[t]) - longint'(pt_x[c]);
        dy = longint'(trk_y[t]) - longint'(pt_y[c]);
        d = dx * dx + dy * dy;
        if (d < lim && (!found || d < bestd)) begin
          found = 1'b1; best = c; bestd = d;
        end
      end
      if (found) begin
        pt_used[best] = 1'b1;
        trk_x[kept] = pt_x[best];
        trk_y[kept] = pt_y[best];
        trk_id[kept] = trk_id[t];
        kept++;
      end
    end
    trk_n = kept;
    for (int c = 0; c < pt_n; c++) begin
      if (!pt_used[c] && trk_n < NTRK) begin
        trk_x[trk_n] = pt_x[c];
        trk_y[trk_n] = pt_y[c];
        trk_id[trk_n] = ident_next;
        ident_next++;
        trk_n++;
      end
    end
    pt_n = 0;
    for (int c = 0; c < NPT; c++) pt_used[c] = 1'b0;
    if (trk_n == 0) begin
      p = '0;
      p.last = 1'b1;
      expected_persons = {expected_persons, p};
    end else begin
      for (int t = 0; t < trk_n; t++) begin
        p.pv = 1'b1; p.id = trk_id[t]; p.x = trk_x[t]; p.y = trk_y[t];
        p.is_new = (t >= kept); p.last = (t == trk_n - 1);
        expected_persons = {expected_persons, p};
      end
    end
  endtask

  // Driver: offers queued requests, with random gaps between them. When the drawn gap
  // is zero and another request is queued, in_valid stays high without a dip.
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_frame('{in_kind, in_point_x, in_point_y});
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !drv_hold) begin
          in_valid <= 1'b1;
          in_kind <= pending_reqs[0].kind;
          in_point_x <= pending_reqs[0].px;
          in_point_y <= pending_reqs[0].py;
          void'(pending_reqs.pop_front());
          gap_left <= ($urandom_range(0, 9) < 6) ? 0 :
                      ($urandom_range(0, 19) == 0 ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 4));
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result against the oldest expectation, and
  // stalls the output at random or for a long hold-off.
  person_t got, want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_person_valid, out_person_id, out_pos_x, out_pos_y, out_is_new, out_last};
        if (expected_persons.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = expected_persons.pop_front();
          if (got.pv !== want.pv)
            $display("%0t: person_valid expected %0d got %0d", $time, want.pv, got.pv);
          if (got.id !== want.id)
            $display("%0t: person_id expected %0d got %0d", $time, want.id, got.id);
          if (got.x !== want.x)
            $display("%0t: pos_x expected %0d got %0d", $time, want.x, got.x);
          if (got.y !== want.y)
            $display("%0t: pos_y expected %0d got %0d", $time, want.y, got.y);
          if (got.is_new !== want.is_new)
            $display("%0t: is_new expected %0d got %0d", $time, want.is_new, got.is_new);
          if (got.last !== want.last)
            $display("%0t: last expected %0d got %0d", $time, want.last, got.last);
          if (got !== want) errors++;
        end
      end
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
        rx_hold <= $urandom_range(20, 60);
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 25);
      end
    end
  end

  task automatic push_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    det_req_t r;
    r = '{1'b0, x, y};
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic push_frame_end();
    det_req_t r;
    r = '{1'b1, COORD_W'($urandom), COORD_W'($urandom)};
    pending_reqs = {pending_reqs, r};
  endtask

  // Waits for the block to drain fully, then lets the matcher settle.
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_persons.size() > 0)
      @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_MATCH_RADIUS) radius_q = val[RADIUS_W-1:0];
    else bias_q = val[BIAS_W-1:0];
    @(posedge clk);
  endtask

  // Random frame: mostly points clustered around existing tracks so that
  // matches, ties of the greedy order and new tracks all occur.
  task automatic random_frame(int npts, bit wild);
    logic [COORD_W-1:0] x, y;
    for (int i = 0; i < npts; i++) begin
      if (!wild && trk_n > 0 && $urandom_range(0, 3) != 0) begin
        x = trk_x[$urandom_range(0, trk_n - 1)] + COORD_W'($urandom_range(0, 600)) - 14'd300;
        y = trk_y[$urandom_range(0, trk_n - 1)] + COORD_W'($urandom_range(0, 600)) - 14'd300;
      end else begin
        x = ($urandom_range(0, 9) == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, 15359));
        y = ($urandom_range(0, 9) == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, 8639));
      end
      push_point(x, y);
    end
    push_frame_end();
  endtask

  initial begin
    radius_q = RADIUS_RESET;
    bias_q = BIAS_RESET;
    trk_n = 0; pt_n = 0; ident_next = '0;
    for (int c = 0; c < NPT; c++) pt_used[c] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, zone edges, extremes and a tie.
    push_frame_end();
    push_point(14'd0, 14'd0);
    push_point(14'd5119, 14'd2879);
    push_point(14'd5120, 14'd2880);
    push_point(14'd10239, 14'd5759);
    push_point(14'd10240, 14'd5760);
    push_point(14'h3FFF, 14'h3FFF);
    push_frame_end();
    push_point(14'd5120, 14'd2880);
    push_point(14'd5120, 14'd2880);
    push_frame_end();
    push_frame_end();
    push_frame_end();
    wait_drained();

    // Buffer and table full: 34 points then an end of frame.
    write_reg(REG_MATCH_RADIUS, 10'd0);
    write_reg(REG_ZONE_BIAS, 10'd63);
    for (int i = 0; i < 34; i++)
      push_point(COORD_W'($urandom_range(0, 15359)), COORD_W'($urandom_range(0, 8639)));
    push_frame_end();
    for (int i = 0; i < 5; i++)
      push_point(COORD_W'($urandom_range(0, 15359)), COORD_W'($urandom_range(0, 8639)));
    push_frame_end();
    wait_drained();

    // Long receiver hold-off while the sender keeps offering points and frames.
    write_reg(REG_MATCH_RADIUS, 10'd1023);
    write_reg(REG_ZONE_BIAS, 10'd0);
    rx_hold = 400;
    random_frame(4, 1'b0);
    random_frame(3, 1'b0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_MATCH_RADIUS, 10'd100);
          write_reg(REG_ZONE_BIAS, 10'd20);
        end
        1: begin
          write_reg(REG_MATCH_RADIUS, 10'd8);
          write_reg(REG_ZONE_BIAS, 10'd63);
        end
        2: begin
          write_reg(REG_MATCH_RADIUS, 10'($urandom_range(0, 1023)));
          write_reg(REG_ZONE_BIAS, 10'($urandom_range(0, 63)));
        end
        default: begin
          write_reg(REG_MATCH_RADIUS, 10'd1023);
          write_reg(REG_ZONE_BIAS, 10'd0);
        end
      endcase
      for (int f = 0; f < 12; f++) begin
        random_frame($urandom_range(0, 9) == 0 ? $urandom_range(20, 34)
                                             : $urandom_range(0, 6),
                     $urandom_range(0, 4) == 0);
        // Sender pause until every expected result has come.
        if (f == 5) begin
          drv_hold = 1'b1;
          @(posedge clk);
          while (in_valid || expected_persons.size() > 0) @(posedge clk);
          drv_hold = 1'b0;
        end
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
rtl/gntm_pkg.sv
rtl/gntm_ram.sv
rtl/gntm_dist.sv
rtl/greedy_nearest_track_matcher_core.sv
bench/tb_greedy_nearest_track_matcher_core.sv
